// File: src/csrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrc_pkg
// Shared widths, stage counts and register indexes for the RGBC calibrator.
// ----------------------------------------------------------------------------
package csrc_pkg;

    localparam int CH_W       = 16;                     // raw sensor count
    localparam int OUT_W      = 8;                      // calibrated channel
    localparam int GAIN_W     = 16;                     // gain register width
    localparam int GAIN_FRAC  = 8;                      // gain fraction bits
    localparam int REF_W      = 3 * CH_W;               // packed reference width
    localparam int CFG_W      = REF_W;                  // widest register
    localparam int CFG_IDX_W  = 3;
    localparam int PROD_W     = CH_W + GAIN_W;          // channel * gain
    localparam int NUM_W      = PROD_W + OUT_W + 1;     // *255 plus rounding term
    localparam int DEN_W      = CH_W + GAIN_FRAC;       // clear << frac
    localparam int REM_W      = DEN_W + OUT_W;          // remainder below den*256
    localparam int DIV_STG    = OUT_W;                  // one quotient bit a stage
    localparam int PRE_STG    = 3;                      // operand, scale, saturate
    localparam int STAGES     = PRE_STG + DIV_STG;
    localparam int P565_W     = 16;
    localparam int P888_W     = 3 * OUT_W;

    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    typedef logic [STAGES-1:0] t_adv;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAL_MODE   = 3'd0,
        REG_GAIN_RED   = 3'd1,
        REG_GAIN_GREEN = 3'd2,
        REG_GAIN_BLUE  = 3'd3,
        REG_BLACK_REFS = 3'd4,
        REG_WHITE_REFS = 3'd5
    } t_cfg_idx;

    localparam logic [GAIN_W-1:0] GAIN_RESET  = GAIN_W'(1 << GAIN_FRAC);
    localparam logic [REF_W-1:0]  WHITE_RESET = {3{CH_W'(255)}};

endpackage

// File: src/csrc_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrc_lane
// One colour channel: operand set-up, scaling, saturation check and an
// eight-stage restoring divider giving a saturated byte.
// ----------------------------------------------------------------------------
module csrc_lane (
    input  logic                       i_clk,
    input  csrc_pkg::t_adv             i_adv,
    input  logic                       i_mode,
    input  logic [csrc_pkg::CH_W-1:0]  i_clr,
    input  logic [csrc_pkg::CH_W-1:0]  i_ch,
    input  logic [csrc_pkg::GAIN_W-1:0] i_gain,
    input  logic [csrc_pkg::CH_W-1:0]  i_blk,
    input  logic [csrc_pkg::CH_W-1:0]  i_wht,
    output logic [csrc_pkg::OUT_W-1:0] o_res
);
    import csrc_pkg::*;

    // operand stage
    logic [PROD_W-1:0] r_prod;
    logic [CH_W-1:0]   r_diff;
    logic [CH_W-1:0]   r_span;
    logic [CH_W-1:0]   r_clr;
    logic              r_mode;
    logic              r_z0;
    // scale stage
    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;
    logic              r_z1;
    // divider stages, index 0 is the saturation stage
    logic [REM_W-1:0]  r_rem [0:DIV_STG];
    logic [DEN_W-1:0]  r_dv  [0:DIV_STG];
    logic [OUT_W-1:0]  r_q   [0:DIV_STG];
    logic              r_sat [0:DIV_STG];
    logic              r_z   [0:DIV_STG];

    logic [REM_W-1:0]  n_rem [1:DIV_STG];
    logic [OUT_W-1:0]  n_q   [1:DIV_STG];
    logic              n_z0;
    logic [NUM_W-1:0]  n_num;
    logic [NUM_W-1:0]  w_lim;

    assign n_z0 = (i_clr == '0) || (i_mode && ((i_wht <= i_blk) || (i_ch <= i_blk)));

    // ch*gain*255 = (p << 8) - p, rounding adds half of clear << frac; cal mode: (ch-blk)*255
    always_comb begin
        if (r_mode) begin
            n_num = NUM_W'({r_diff, OUT_W'(0)}) - NUM_W'(r_diff);
        end else begin
            n_num = NUM_W'({r_prod, OUT_W'(0)}) - NUM_W'(r_prod)
                  + NUM_W'({r_clr, (GAIN_FRAC-1)'(0)});
        end
    end

    assign w_lim = NUM_W'({r_den, OUT_W'(0)});

    always_comb begin
        for (int j = 1; j <= DIV_STG; j++) begin
            logic [REM_W-1:0] v_trial;
            v_trial = REM_W'(r_dv[j-1]) << (DIV_STG - j);
            if (r_rem[j-1] >= v_trial) begin
                n_rem[j] = r_rem[j-1] - v_trial;
                n_q[j]   = r_q[j-1] | (OUT_W'(1) << (DIV_STG - j));
            end else begin
                n_rem[j] = r_rem[j-1];
                n_q[j]   = r_q[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r_prod <= i_ch * i_gain;
            r_diff <= i_ch - i_blk;
            r_span <= i_wht - i_blk;
            r_clr  <= i_clr;
            r_mode <= i_mode;
            r_z0   <= n_z0;
        end
        if (i_adv[1]) begin
            r_num <= n_num;
            r_den <= r_mode ? DEN_W'(r_span) : {r_clr, GAIN_FRAC'(0)};
            r_z1  <= r_z0;
        end
        if (i_adv[2]) begin
            r_rem[0] <= r_num[REM_W-1:0];
            r_dv[0]  <= r_den;
            r_q[0]   <= '0;
            r_sat[0] <= (r_num >= w_lim);
            r_z[0]   <= r_z1;
        end
        for (int j = 1; j <= DIV_STG; j++) begin
            if (i_adv[PRE_STG-1+j]) begin
                r_rem[j] <= n_rem[j];
                r_dv[j]  <= r_dv[j-1];
                r_q[j]   <= n_q[j];
                r_sat[j] <= r_sat[j-1];
                r_z[j]   <= r_z[j-1];
            end
        end
    end

    assign o_res = r_z[DIV_STG] ? '0 : (r_sat[DIV_STG] ? OUT_MAX : r_q[DIV_STG]);

endmodule

// File: src/csrc_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrc_merge
// Combine the three lane results into one output word and hold it until taken.
// ----------------------------------------------------------------------------
module csrc_merge (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    output logic                        o_rdy,
    input  logic [csrc_pkg::CH_W-1:0]   i_clr,
    input  logic [csrc_pkg::OUT_W-1:0]  i_red,
    input  logic [csrc_pkg::OUT_W-1:0]  i_green,
    input  logic [csrc_pkg::OUT_W-1:0]  i_blue,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [csrc_pkg::CH_W-1:0]   o_clear_out,
    output logic [csrc_pkg::OUT_W-1:0]  o_red_out,
    output logic [csrc_pkg::OUT_W-1:0]  o_green_out,
    output logic [csrc_pkg::OUT_W-1:0]  o_blue_out,
    output logic [csrc_pkg::P888_W-1:0] o_packed_888,
    output logic [csrc_pkg::P565_W-1:0] o_packed_565
);
    import csrc_pkg::*;

    logic r_vld;

    assign o_rdy   = !r_vld || i_ready;
    assign o_valid = r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            o_clear_out  <= i_clr;
            o_red_out    <= i_red;
            o_green_out  <= i_green;
            o_blue_out   <= i_blue;
            o_packed_888 <= {i_red, i_green, i_blue};
            o_packed_565 <= {i_red[7:3], i_green[7:2], i_blue[7:3]};
        end
    end

endmodule

// File: src/color_sensor_rgb_calibrate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_sensor_rgb_calibrate
// Calibrates one raw clear/red/green/blue sample set to 8-bit RGB.
// Each sample passes the 11 lane stages, then one output register, before o_valid.
// Throughput: one word per cycle while the output word is not held; the
// per-lane divider takes one quotient bit per stage, three lanes in parallel.
// Reset (synchronous, active low) empties the pipeline and returns every
// configuration register to its reset value.
// ----------------------------------------------------------------------------
module color_sensor_rgb_calibrate (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [csrc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [csrc_pkg::CFG_W-1:0]     i_cfg_data,
    // sample input
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [csrc_pkg::CH_W-1:0]      i_clear_in,
    input  logic [csrc_pkg::CH_W-1:0]      i_red_in,
    input  logic [csrc_pkg::CH_W-1:0]      i_green_in,
    input  logic [csrc_pkg::CH_W-1:0]      i_blue_in,
    // result output
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [csrc_pkg::CH_W-1:0]      o_clear_out,
    output logic [csrc_pkg::OUT_W-1:0]     o_red_out,
    output logic [csrc_pkg::OUT_W-1:0]     o_green_out,
    output logic [csrc_pkg::OUT_W-1:0]     o_blue_out,
    output logic [csrc_pkg::P888_W-1:0]    o_packed_888,
    output logic [csrc_pkg::P565_W-1:0]    o_packed_565
);
    import csrc_pkg::*;

    // configuration registers
    logic              r_cal_mode;
    logic [GAIN_W-1:0] r_gain_red;
    logic [GAIN_W-1:0] r_gain_green;
    logic [GAIN_W-1:0] r_gain_blue;
    logic [REF_W-1:0]  r_black_refs;
    logic [REF_W-1:0]  r_white_refs;

    // pipeline occupancy and the clear count riding alongside the lanes
    logic [STAGES-1:0] r_vld;
    logic [CH_W-1:0]   r_clr [0:STAGES-1];
    t_adv              w_adv;
    logic              w_merge_rdy;

    logic [OUT_W-1:0]  w_red;
    logic [OUT_W-1:0]  w_green;
    logic [OUT_W-1:0]  w_blue;

    // Write registers by index; drop writes to unknown indexes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_mode   <= 1'b0;
            r_gain_red   <= GAIN_RESET;
            r_gain_green <= GAIN_RESET;
            r_gain_blue  <= GAIN_RESET;
            r_black_refs <= '0;
            r_white_refs <= WHITE_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                REG_CAL_MODE:   r_cal_mode   <= i_cfg_data[0];
                REG_GAIN_RED:   r_gain_red   <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_GREEN: r_gain_green <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_BLUE:  r_gain_blue  <= i_cfg_data[GAIN_W-1:0];
                REG_BLACK_REFS: r_black_refs <= i_cfg_data[REF_W-1:0];
                REG_WHITE_REFS: r_white_refs <= i_cfg_data[REF_W-1:0];
                default: ;
            endcase
        end
    end

    // A stage advances when it is empty or its successor advances, so bubbles
    // collapse and a full pipeline stalls only when the output word is held.
    always_comb begin
        w_adv[STAGES-1] = !r_vld[STAGES-1] || w_merge_rdy;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign o_ready = w_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Carry the clear count down the pipe; it leaves unchanged.
    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_clr[0] <= i_clear_in;
        end
        for (int k = 1; k < STAGES; k++) begin
            if (w_adv[k]) begin
                r_clr[k] <= r_clr[k-1];
            end
        end
    end

    // One lane per colour; each sees its own gain and reference slice.
    csrc_lane u_lane_red (
        .i_clk  (i_clk),
        .i_adv  (w_adv),
        .i_mode (r_cal_mode),
        .i_clr  (i_clear_in),
        .i_ch   (i_red_in),
        .i_gain (r_gain_red),
        .i_blk  (r_black_refs[CH_W-1:0]),
        .i_wht  (r_white_refs[CH_W-1:0]),
        .o_res  (w_red)
    );

    csrc_lane u_lane_green (
        .i_clk  (i_clk),
        .i_adv  (w_adv),
        .i_mode (r_cal_mode),
        .i_clr  (i_clear_in),
        .i_ch   (i_green_in),
        .i_gain (r_gain_green),
        .i_blk  (r_black_refs[2*CH_W-1:CH_W]),
        .i_wht  (r_white_refs[2*CH_W-1:CH_W]),
        .o_res  (w_green)
    );

    csrc_lane u_lane_blue (
        .i_clk  (i_clk),
        .i_adv  (w_adv),
        .i_mode (r_cal_mode),
        .i_clr  (i_clear_in),
        .i_ch   (i_blue_in),
        .i_gain (r_gain_blue),
        .i_blk  (r_black_refs[3*CH_W-1:2*CH_W]),
        .i_wht  (r_white_refs[3*CH_W-1:2*CH_W]),
        .o_res  (w_blue)
    );

    // Pack the lane results and hold the word for the consumer.
    csrc_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vld        (r_vld[STAGES-1]),
        .o_rdy        (w_merge_rdy),
        .i_clr        (r_clr[STAGES-1]),
        .i_red        (w_red),
        .i_green      (w_green),
        .i_blue       (w_blue),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_clear_out  (o_clear_out),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out),
        .o_packed_888 (o_packed_888),
        .o_packed_565 (o_packed_565)
    );

endmodule
